FILE: rtl/pngenc_pkg.sv
// Shared types, constants and helper functions of the PNG stored-deflate encoder.
package pngenc_pkg;

  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int RAWL_W         = 26;
  localparam int MAX_RESULTS    = 52;
  localparam int OCNT_W         = 6;
  localparam int ADLER_MOD      = 65521;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_BLOCK_MAX  = 65535;

  localparam logic [CFG_W-1:0] DEF_WIDTH  = 13'd256;
  localparam logic [CFG_W-1:0] DEF_HEIGHT = 13'd240;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;

  localparam logic [7:0] ZLIB_CMF       = 8'h78;
  localparam logic [7:0] ZLIB_FLG       = 8'h01;
  localparam logic [7:0] BIT_DEPTH      = 8'd8;
  localparam logic [7:0] COLOR_TYPE_RGB = 8'd2;
  localparam logic [7:0] HDR_DATA_LEN   = 8'd13;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_HEAD  = 6'b000010,
    ST_BHDR  = 6'b000100,
    ST_DATA  = 6'b001000,
    ST_TRAIL = 6'b010000,
    ST_FLUSH = 6'b100000
  } seq_state_t;

  typedef enum logic [4:0] {
    DV_IDLE = 5'b00001,
    DV_MUL  = 5'b00010,
    DV_LOAD = 5'b00100,
    DV_DIV  = 5'b01000,
    DV_FIN  = 5'b10000
  } div_state_t;

  function automatic logic [7:0] magic_byte(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h89;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h0D;
      3'd5:    r = 8'h0A;
      3'd6:    r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] be_byte(logic [31:0] w, logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > hi) begin
      r = CFG_W'(hi);
    end
    return r;
  endfunction

endpackage

FILE: rtl/pngenc_if.sv
// Valid/ready channel interfaces for pixels in and file bytes out.
interface pngenc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface pngenc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_end;

  modport source (output valid, output out_byte, output run_last, output file_end, input ready);
  modport sink (input valid, input out_byte, input run_last, input file_end, output ready);
endinterface

FILE: rtl/pngenc_queue.sv
// Front end: accepts pixels and holds them in a two-entry queue for the byte sequencer.
module pngenc_queue import pngenc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  pngenc_pix_if.sink    in_pix,
  output logic          q_valid,
  output pix_t          q_data,
  input  logic          q_pop
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  pix_t            mem_r [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r;
  logic [AW-1:0]   rp_r;
  logic [AW:0]     cnt_r;
  logic            push;
  logic            pop;

  assign in_pix.ready = (cnt_r != (AW+1)'(QUEUE_DEPTH));
  assign q_valid      = (cnt_r != '0);
  assign q_data       = mem_r[rp_r];
  assign push         = in_pix.valid && in_pix.ready;
  assign pop          = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{red: in_pix.red, green: in_pix.green, blue: in_pix.blue};
    end
  end

endmodule

FILE: rtl/pngenc_div.sv
// Frame length unit: raw size, stored block count by reciprocal multiplication, IDAT length.
module pngenc_div import pngenc_pkg::*; #(
  parameter int BLOCK_MAX = DEF_BLOCK_MAX,
  parameter int RAW_W     = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CFG_W-1:0] w_i,
  input  logic [CFG_W-1:0] h_i,
  output logic             done,
  output logic [RAW_W-1:0] raw_o,
  output logic [31:0]      len_o
);

  localparam int BW = $clog2(BLOCK_MAX + 1);
  localparam int NW = ((RAW_W > BW) ? RAW_W : BW) + 1;
  localparam int SH = NW + $clog2(BLOCK_MAX);
  localparam int MW = NW + 2;
  localparam int PW = NW + MW;
  localparam longint unsigned RECIP =
    ((longint'(1) << SH) + longint'(BLOCK_MAX) - longint'(1)) / longint'(BLOCK_MAX);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  div_state_t        st_r;
  logic              done_r;
  logic [CFG_W-1:0]  w_r;
  logic [CFG_W-1:0]  h_r;
  logic [RAW_W-1:0]  raw_r;
  logic [NW-1:0]     num_r;
  logic [NW-1:0]     quot_r;
  logic [31:0]       len_r;
  logic [14:0]       mfac;
  logic [27:0]       prod;
  logic [PW-1:0]     qprod;

  // The block count is the rounded-up quotient, taken exactly by a scaled reciprocal.
  assign mfac  = {2'b0, w_r} + {1'b0, w_r, 1'b0} + 15'd1;
  assign prod  = 28'(h_r) * 28'(mfac);
  assign qprod = PW'(num_r) * PW'(RECIP_M);

  assign done  = done_r;
  assign raw_o = raw_r;
  assign len_o = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else if (start) begin
      st_r   <= DV_MUL;
      done_r <= 1'b0;
    end else begin
      unique case (st_r)
        DV_IDLE: ;
        DV_MUL:  st_r <= DV_LOAD;
        DV_LOAD: st_r <= DV_DIV;
        DV_DIV:  st_r <= DV_FIN;
        DV_FIN: begin
          done_r <= 1'b1;
          st_r   <= DV_IDLE;
        end
        default: st_r <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r <= w_i;
      h_r <= h_i;
    end
    if (st_r == DV_MUL) begin
      raw_r <= RAW_W'(prod);
    end
    if (st_r == DV_LOAD) begin
      num_r <= NW'(raw_r) + NW'(BLOCK_MAX - 1);
    end
    if (st_r == DV_DIV) begin
      quot_r <= NW'(qprod >> SH);
    end
    if (st_r == DV_FIN) begin
      len_r <= 32'd6 + (32'(quot_r) << 2) + 32'(quot_r) + 32'(raw_r);
    end
  end

endmodule

FILE: rtl/pngenc_seq.sv
// Back end: byte sequencer with chunk CRC, Adler-32, stored block framing and output register.
module pngenc_seq import pngenc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int BLOCK_MAX  = DEF_BLOCK_MAX,
  parameter int RAW_W      = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] cfg_width,
  input  logic [CFG_W-1:0] cfg_height,
  input  logic             q_valid,
  input  pix_t             q_data,
  output logic             q_pop,
  output logic             div_start,
  output logic [CFG_W-1:0] div_w,
  output logic [CFG_W-1:0] div_h,
  input  logic             div_done,
  input  logic [RAW_W-1:0] div_raw,
  input  logic [31:0]      div_len,
  pngenc_byte_if.source    out_bytes
);

  localparam int BW    = $clog2(BLOCK_MAX + 1);
  localparam int IDX_W = 6;

  localparam logic [IDX_W-1:0] HEAD_LEN_IDX  = 6'd33;
  localparam logic [IDX_W-1:0] HEAD_END_IDX  = 6'd42;
  localparam logic [IDX_W-1:0] BHDR_END_IDX  = 6'd4;
  localparam logic [IDX_W-1:0] TRAIL_END_IDX = 6'd19;

  localparam logic [1:0] COMP_FILTER = 2'd0;
  localparam logic [1:0] COMP_RED    = 2'd1;
  localparam logic [1:0] COMP_GREEN  = 2'd2;
  localparam logic [1:0] COMP_BLUE   = 2'd3;

  localparam logic [RAWL_W-1:0] BLK_L        = RAWL_W'(BLOCK_MAX);
  localparam logic [OCNT_W-1:0] OCNT_MAX     = OCNT_W'(MAX_RESULTS);
  localparam logic [OCNT_W-1:0] OCNT_LASTPOS = OCNT_W'(MAX_RESULTS - 1);
  localparam logic [16:0]       AMOD         = 17'(ADLER_MOD);

  seq_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         comp_r, comp_nxt;
  pix_t               pix_r, pix_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic [15:0]        alo_r, alo_nxt;
  logic [15:0]        ahi_r, ahi_nxt;
  logic [CFG_W-1:0]   col_r, col_nxt;
  logic [BW-1:0]      blk_r, blk_nxt;
  logic [RAWL_W-1:0]  rawl_r, rawl_nxt;
  logic               frm_r, frm_nxt;
  logic [OCNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [7:0]         hold_r, hold_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic               ended_r, ended_nxt;
  logic [CFG_W-1:0]   w_r, w_nxt;
  logic [CFG_W-1:0]   h_r, h_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         ob_r, ob_nxt;
  logic               orl_r, orl_nxt;
  logic               ofe_r, ofe_nxt;

  logic               gen;
  logic [7:0]         b;
  logic               crc_on;
  logic               crc_rst;
  logic               more;
  logic               keep;
  logic               last_pos;
  logic               to_out;
  logic               to_hold;
  logic               slot;
  logic               adv;
  logic               step_done;
  logic               start;
  logic [CFG_W-1:0]   wlive;
  logic [BW-1:0]      blk_n;
  logic [15:0]        n16;
  logic [31:0]        crc_in;
  logic [16:0]        s1;
  logic [15:0]        lo_n;
  logic [16:0]        s2;
  logic [CFG_W:0]     c1;
  logic [31:0]        raw32;

  assign wlive = clamp_dim(cfg_width, MAX_WIDTH);
  assign blk_n = (rawl_r <= BLK_L) ? BW'(rawl_r) : BW'(BLOCK_MAX);
  assign n16   = 16'(blk_n);
  assign raw32 = 32'(div_raw);
  assign s1    = {1'b0, alo_r} + 17'(b);
  assign lo_n  = (s1 >= AMOD) ? 16'(s1 - AMOD) : 16'(s1);
  assign s2    = {1'b0, ahi_r} + {1'b0, lo_n};
  assign c1    = {1'b0, col_r} + (CFG_W+1)'(1);
  assign crc_in = crc_rst ? CRC_INIT : crc_r;

  assign div_w = clamp_dim(cfg_width, MAX_WIDTH);
  assign div_h = clamp_dim(cfg_height, MAX_HEIGHT);

  always_comb begin
    gen     = 1'b0;
    b       = 8'd0;
    crc_on  = 1'b0;
    crc_rst = 1'b0;
    more    = 1'b1;
    unique case (state_r)
      ST_HEAD: begin
        gen     = !((idx_r == HEAD_LEN_IDX) && !div_done);
        crc_on  = ((idx_r >= 6'd12) && (idx_r <= 6'd28)) || (idx_r >= 6'd37);
        crc_rst = (idx_r == 6'd12) || (idx_r == 6'd37);
        unique case (idx_r) inside
          [6'd0:6'd7]:   b = magic_byte(idx_r[2:0]);
          [6'd8:6'd10]:  b = 8'd0;
          6'd11:         b = HDR_DATA_LEN;
          [6'd12:6'd15]: b = be_byte(TYPE_IHDR, idx_r[1:0]);
          [6'd16:6'd19]: b = be_byte(32'(w_r), idx_r[1:0]);
          [6'd20:6'd23]: b = be_byte(32'(h_r), idx_r[1:0]);
          6'd24:         b = BIT_DEPTH;
          6'd25:         b = COLOR_TYPE_RGB;
          [6'd26:6'd28]: b = 8'd0;
          [6'd29:6'd32]: b = be_byte(~crc_r, 2'(idx_r - 6'd29));
          [6'd33:6'd36]: b = be_byte(div_len, 2'(idx_r - 6'd33));
          [6'd37:6'd40]: b = be_byte(TYPE_IDAT, 2'(idx_r - 6'd37));
          6'd41:         b = ZLIB_CMF;
          default:       b = ZLIB_FLG;
        endcase
      end
      ST_BHDR: begin
        gen    = 1'b1;
        crc_on = 1'b1;
        case (idx_r)
          6'd0:    b = {7'd0, (rawl_r <= BLK_L)};
          6'd1:    b = n16[7:0];
          6'd2:    b = n16[15:8];
          6'd3:    b = ~n16[7:0];
          default: b = ~n16[15:8];
        endcase
      end
      ST_DATA: begin
        gen    = (blk_r != '0);
        crc_on = 1'b1;
        more   = !((comp_r == COMP_BLUE) && (rawl_r != RAWL_W'(1)));
        case (comp_r)
          COMP_FILTER: b = 8'd0;
          COMP_RED:    b = pix_r.red;
          COMP_GREEN:  b = pix_r.green;
          default:     b = pix_r.blue;
        endcase
      end
      ST_TRAIL: begin
        gen     = 1'b1;
        crc_on  = (idx_r < 6'd4) || ((idx_r >= 6'd12) && (idx_r <= 6'd15));
        crc_rst = (idx_r == 6'd12);
        more    = (idx_r != TRAIL_END_IDX);
        case (idx_r[4:2])
          3'd0:    b = be_byte({ahi_r, alo_r}, idx_r[1:0]);
          3'd1:    b = be_byte(~crc_r, idx_r[1:0]);
          3'd2:    b = 8'd0;
          3'd3:    b = be_byte(TYPE_IEND, idx_r[1:0]);
          default: b = be_byte(~crc_r, idx_r[1:0]);
        endcase
      end
      default: ;
    endcase
  end

  assign keep     = (ocnt_r < OCNT_MAX);
  assign last_pos = (ocnt_r == OCNT_LASTPOS);
  assign to_out   = gen && keep && !(last_pos && more);
  assign to_hold  = gen && keep && last_pos && more;
  assign slot     = !ov_r || out_bytes.ready;
  assign adv      = gen && (!to_out || slot);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    comp_nxt   = comp_r;
    pix_nxt    = pix_r;
    crc_nxt    = crc_r;
    alo_nxt    = alo_r;
    ahi_nxt    = ahi_r;
    col_nxt    = col_r;
    blk_nxt    = blk_r;
    rawl_nxt   = rawl_r;
    frm_nxt    = frm_r;
    ocnt_nxt   = ocnt_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    ended_nxt  = ended_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    ov_nxt     = ov_r;
    ob_nxt     = ob_r;
    orl_nxt    = orl_r;
    ofe_nxt    = ofe_r;
    step_done  = 1'b0;
    div_start  = 1'b0;

    if (ov_r && out_bytes.ready) begin
      ov_nxt = 1'b0;
    end

    if (adv) begin
      if (crc_on) begin
        crc_nxt = crc_byte(crc_in, b);
      end
      if (keep) begin
        ocnt_nxt = ocnt_r + OCNT_W'(1);
      end
      if (to_out) begin
        ov_nxt  = 1'b1;
        ob_nxt  = b;
        orl_nxt = !more;
        ofe_nxt = !more && (state_r == ST_TRAIL);
      end
      if (to_hold) begin
        hold_nxt   = b;
        hold_v_nxt = 1'b1;
      end
      if (!more) begin
        if (hold_v_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          step_done = 1'b1;
        end
      end
      unique case (state_r)
        ST_HEAD: begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == HEAD_END_IDX) begin
            alo_nxt  = 16'd1;
            ahi_nxt  = 16'd0;
            col_nxt  = '0;
            blk_nxt  = '0;
            rawl_nxt = raw32[RAWL_W-1:0];
            frm_nxt  = 1'b1;
            idx_nxt  = '0;
            if (raw32[RAWL_W-1:0] == '0) begin
              state_nxt = ST_TRAIL;
              ended_nxt = 1'b1;
            end else begin
              state_nxt = ST_DATA;
              comp_nxt  = COMP_FILTER;
            end
          end
        end
        ST_BHDR: begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == BHDR_END_IDX) begin
            blk_nxt   = blk_n;
            state_nxt = ST_DATA;
          end
        end
        ST_DATA: begin
          alo_nxt  = lo_n;
          ahi_nxt  = (s2 >= AMOD) ? 16'(s2 - AMOD) : 16'(s2);
          blk_nxt  = blk_r - BW'(1);
          rawl_nxt = rawl_r - RAWL_W'(1);
          if (rawl_r == RAWL_W'(1)) begin
            state_nxt = ST_TRAIL;
            idx_nxt   = '0;
            ended_nxt = 1'b1;
          end else if (comp_r == COMP_BLUE) begin
            col_nxt = (c1 >= {1'b0, wlive}) ? '0 : CFG_W'(c1);
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
        ST_TRAIL: begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == TRAIL_END_IDX) begin
            frm_nxt = 1'b0;
            col_nxt = '0;
            blk_nxt = '0;
          end
        end
        default: ;
      endcase
    end else if ((state_r == ST_DATA) && (blk_r == '0)) begin
      state_nxt = ST_BHDR;
      idx_nxt   = '0;
    end else if ((state_r == ST_FLUSH) && slot) begin
      ov_nxt     = 1'b1;
      ob_nxt     = hold_r;
      orl_nxt    = 1'b1;
      ofe_nxt    = ended_r;
      hold_v_nxt = 1'b0;
      step_done  = 1'b1;
    end

    if (step_done) begin
      state_nxt = ST_IDLE;
    end

    start = ((state_r == ST_IDLE) || step_done) && q_valid;
    if (start) begin
      pix_nxt    = q_data;
      ocnt_nxt   = '0;
      hold_v_nxt = 1'b0;
      ended_nxt  = 1'b0;
      idx_nxt    = '0;
      if (!frm_nxt) begin
        state_nxt = ST_HEAD;
        w_nxt     = div_w;
        h_nxt     = div_h;
        div_start = 1'b1;
      end else begin
        state_nxt = ST_DATA;
        comp_nxt  = (col_nxt == '0) ? COMP_FILTER : COMP_RED;
      end
    end
    q_pop = start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      comp_r   <= COMP_FILTER;
      crc_r    <= CRC_INIT;
      alo_r    <= 16'd1;
      ahi_r    <= 16'd0;
      col_r    <= '0;
      blk_r    <= '0;
      rawl_r   <= '0;
      frm_r    <= 1'b0;
      ocnt_r   <= '0;
      hold_v_r <= 1'b0;
      ended_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      comp_r   <= comp_nxt;
      crc_r    <= crc_nxt;
      alo_r    <= alo_nxt;
      ahi_r    <= ahi_nxt;
      col_r    <= col_nxt;
      blk_r    <= blk_nxt;
      rawl_r   <= rawl_nxt;
      frm_r    <= frm_nxt;
      ocnt_r   <= ocnt_nxt;
      hold_v_r <= hold_v_nxt;
      ended_r  <= ended_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r  <= pix_nxt;
    hold_r <= hold_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    ob_r   <= ob_nxt;
    orl_r  <= orl_nxt;
    ofe_r  <= ofe_nxt;
  end

  assign out_bytes.valid    = ov_r;
  assign out_bytes.out_byte = ob_r;
  assign out_bytes.run_last = orl_r;
  assign out_bytes.file_end = ofe_r;

`ifndef SYNTHESIS
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OCNT_MAX) else $error("Per-pixel byte count exceeded its limit.");
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (ocnt_r == OCNT_MAX)) else $error("Held byte without a full result count.");
  a_flush_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> hold_v_r) else $error("Flush state entered with no held byte.");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ofe_r) |-> orl_r) else $error("File end byte not marked as last of its pixel.");
  a_len_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_HEAD) && (idx_r > HEAD_LEN_IDX)) |-> div_done)
    else $error("Header passed the IDAT length before it was computed.");
`endif

endmodule

FILE: rtl/png_stored_deflate_encoder_top.sv
// Top level of the PNG stored-deflate encoder: configuration registers and unit wiring.
//
// Pixels enter in raster order and the block emits the PNG file one byte per transaction,
// at most one byte per cycle from the sequencer into the output register. A pixel causes
// three bytes, four at the start of a row. The first pixel of a frame adds 43 header
// bytes; the IDAT length comes from the length unit, which steps through its multiply,
// load, divide and finish states and is done long before the header reaches that byte.
// Each stored block adds five header bytes, and the switch into its header makes no byte;
// the last pixel adds 20 trailer bytes. Bytes beyond the 52nd of one pixel are still
// generated but not emitted; the held 52nd byte goes out from the flush state after them.
// A two-entry input queue lets pixels arrive while the sequencer works on earlier ones.
module png_stored_deflate_encoder_top import pngenc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int BLOCK_MAX  = DEF_BLOCK_MAX
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  pngenc_pix_if.sink           in_pix,
  pngenc_byte_if.source        out_bytes
);

  localparam int CFG_MAXV = (1 << CFG_W) - 1;
  localparam int EFF_W    = (MAX_WIDTH < CFG_MAXV) ? MAX_WIDTH : CFG_MAXV;
  localparam int EFF_H    = (MAX_HEIGHT < CFG_MAXV) ? MAX_HEIGHT : CFG_MAXV;
  localparam int RAW_MAX  = EFF_H * (1 + 3 * EFF_W);
  localparam int RAW_W    = $clog2(RAW_MAX + 1);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             q_valid;
  pix_t             q_data;
  logic             q_pop;
  logic             div_start;
  logic [CFG_W-1:0] div_w;
  logic [CFG_W-1:0] div_h;
  logic             div_done;
  logic [RAW_W-1:0] div_raw;
  logic [31:0]      div_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DEF_WIDTH;
      height_r <= DEF_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pngenc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  pngenc_div #(
    .BLOCK_MAX (BLOCK_MAX),
    .RAW_W     (RAW_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .w_i   (div_w),
    .h_i   (div_h),
    .done  (div_done),
    .raw_o (div_raw),
    .len_o (div_len)
  );

  pngenc_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .BLOCK_MAX  (BLOCK_MAX),
    .RAW_W      (RAW_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .div_start  (div_start),
    .div_w      (div_w),
    .div_h      (div_h),
    .div_done   (div_done),
    .div_raw    (div_raw),
    .div_len    (div_len),
    .out_bytes  (out_bytes)
  );

endmodule

FILE: verif/png_stored_deflate_encoder_top_test.sv
// Self-checking testbench for the PNG stored-deflate encoder top level.
`timescale 1ns / 100ps

module png_stored_deflate_encoder_top_test;
  import pngenc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } file_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  pngenc_pix_if pix();
  pngenc_byte_if bytes();

  png_stored_deflate_encoder_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_pix(pix),
    .out_bytes(bytes)
  );

  pix_t pixel_queue[$];
  file_byte_t file_bytes_due[$];
  file_byte_t step_bytes[$];
  bit failed = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 54;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [31:0] crc_acc;
  logic [31:0] adler_lo;
  logic [31:0] adler_hi;
  logic [31:0] col_pos;
  logic [31:0] row_pos;
  logic [31:0] block_left;
  logic [31:0] raw_left;
  bit in_frame;
  int step_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (32'hEDB88320 ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [31:0] saturate_dim(logic [CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return v;
  endfunction

  function void emit_byte(logic [7:0] b, bit with_crc);
    file_byte_t fb;
    if (with_crc) crc_acc = crc32_next(crc_acc, b);
    if (step_count < MAX_RESULTS) begin
      fb.data = b;
      fb.last = 1'b0;
      fb.fend = 1'b0;
      step_bytes.push_back(fb);
    end
    step_count++;
  endfunction

  function void emit_word(logic [31:0] v, bit with_crc);
    for (int i = 3; i >= 0; i--) emit_byte(v[8*i +: 8], with_crc);
  endfunction

  function void emit_chunk_type(logic [31:0] t);
    crc_acc = 32'hFFFFFFFF;
    emit_word(t, 1'b1);
  endfunction

  function void emit_raw(logic [7:0] b);
    logic [31:0] n;
    if (raw_left == 0) return;
    if (block_left == 0) begin
      n = (raw_left < 65535) ? raw_left : 65535;
      emit_byte((raw_left <= 65535) ? 8'd1 : 8'd0, 1'b1);
      emit_byte(n[7:0], 1'b1);
      emit_byte(n[15:8], 1'b1);
      emit_byte(~n[7:0], 1'b1);
      emit_byte(~n[15:8], 1'b1);
      block_left = n;
    end
    emit_byte(b, 1'b1);
    adler_lo = (adler_lo + b) % 65521;
    adler_hi = (adler_hi + adler_lo) % 65521;
    block_left--;
    raw_left--;
  endfunction

  function void open_frame();
    logic [7:0] sig[8];
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] raw;
    logic [31:0] nblk;
    sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    w = saturate_dim(width_reg, 4096);
    h = saturate_dim(height_reg, 4096);
    raw = h * (1 + 3 * w);
    nblk = (raw + 65534) / 65535;
    foreach (sig[i]) emit_byte(sig[i], 1'b0);
    emit_word(32'd13, 1'b0);
    emit_chunk_type(TYPE_IHDR);
    emit_word(w, 1'b1);
    emit_word(h, 1'b1);
    emit_byte(8'd8, 1'b1);
    emit_byte(8'd2, 1'b1);
    emit_byte(8'd0, 1'b1);
    emit_byte(8'd0, 1'b1);
    emit_byte(8'd0, 1'b1);
    emit_word(crc_acc ^ 32'hFFFFFFFF, 1'b0);
    emit_word(2 + nblk * 5 + raw + 4, 1'b0);
    emit_chunk_type(TYPE_IDAT);
    emit_byte(8'h78, 1'b1);
    emit_byte(8'h01, 1'b1);
    adler_lo = 1;
    adler_hi = 0;
    col_pos = 0;
    row_pos = 0;
    block_left = 0;
    raw_left = raw & 32'h3FFFFFF;
    in_frame = 1;
  endfunction

  function void close_frame();
    emit_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
    emit_word(crc_acc ^ 32'hFFFFFFFF, 1'b0);
    emit_word(32'd0, 1'b0);
    emit_chunk_type(TYPE_IEND);
    emit_word(crc_acc ^ 32'hFFFFFFFF, 1'b0);
    in_frame = 0;
    col_pos = 0;
    row_pos = 0;
    block_left = 0;
  endfunction

  function void predict_pixel_bytes(pix_t p);
    logic [31:0] w;
    bit ended;
    ended = 0;
    step_count = 0;
    step_bytes.delete();
    if (!in_frame) open_frame();
    w = saturate_dim(width_reg, 4096);
    if (col_pos == 0) emit_raw(8'd0);
    emit_raw(p.red);
    emit_raw(p.green);
    emit_raw(p.blue);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'hFFF;
    end
    if (raw_left == 0) begin
      close_frame();
      ended = 1;
    end
    step_bytes[step_bytes.size() - 1].last = 1'b1;
    step_bytes[step_bytes.size() - 1].fend = ended;
    foreach (step_bytes[i]) file_bytes_due.push_back(step_bytes[i]);
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    predict_pixel_bytes(p);
    pixel_queue.push_back(p);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || pix.valid || file_bytes_due.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == CFG_IDX_WIDTH) width_reg = val;
    else if (idx == CFG_IDX_HEIGHT) height_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic finish_frame();
    do send_random_pixel(); while (in_frame);
  endtask

  task automatic random_frame();
    int cut;
    write_reg(CFG_IDX_WIDTH, CFG_W'($urandom_range(1, 6)));
    write_reg(CFG_IDX_HEIGHT, CFG_W'($urandom_range(1, 4)));
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut && (i == 0 || in_frame); i++) send_random_pixel();
      wait_drained();
      write_reg(CFG_IDX_WIDTH, CFG_W'($urandom_range(0, 8)));
      if (in_frame) finish_frame();
    end else begin
      finish_frame();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pix_t p;
        p = pixel_queue.pop_front();
        pix.valid <= 1'b1;
        pix.red <= p.red;
        pix.green <= p.green;
        pix.blue <= p.blue;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      bytes.ready <= 1'b0;
    end else begin
      bytes.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (bytes.valid && bytes.ready) begin
        if (file_bytes_due.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual byte %02h", $time,
                   bytes.out_byte);
          failed = 1;
        end else begin
          file_byte_t e;
          e = file_bytes_due.pop_front();
          if (bytes.out_byte !== e.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, e.data,
                     bytes.out_byte);
            failed = 1;
          end
          if (bytes.run_last !== e.last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b", $time, e.last,
                     bytes.run_last);
            failed = 1;
          end
          if (bytes.file_end !== e.fend) begin
            $display("%0t: file_end mismatch: expected %0b, actual %0b", $time, e.fend,
                     bytes.file_end);
            failed = 1;
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    bytes.ready = 1'b0;
    width_reg = DEF_WIDTH;
    height_reg = DEF_HEIGHT;
    crc_acc = 32'hFFFFFFFF;
    adler_lo = 1;
    adler_hi = 0;
    col_pos = 0;
    row_pos = 0;
    block_left = 0;
    raw_left = 0;
    in_frame = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A zero size saturates to a one-pixel frame, whose bytes overflow one pixel's output.
    write_reg(CFG_IDX_WIDTH, 13'd0);
    write_reg(CFG_IDX_HEIGHT, 13'd0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_drained();
    write_reg(CFG_IDX_WIDTH, 13'd2);
    write_reg(CFG_IDX_HEIGHT, 13'd2);
    send_pixel(8'hAA, 8'h55, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'h00, 8'hFF, 8'h55);
    wait_drained();
    // The width changes mid-frame; the declared length still ends the frame.
    write_reg(CFG_IDX_WIDTH, 13'd3);
    write_reg(CFG_IDX_HEIGHT, 13'd2);
    send_random_pixel();
    send_random_pixel();
    wait_drained();
    write_reg(CFG_IDX_WIDTH, 13'd1);
    finish_frame();
    wait_drained();

    repeat (4) random_frame();
    send_idle_pct = 54;
    recv_idle_pct = 8;
    repeat (4) random_frame();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) random_frame();

    repeat (80) @(posedge clk);
    if (!failed && file_bytes_due.size() == 0) begin
      $display("png_stored_deflate_encoder_top_test: PASS");
    end else begin
      $display("png_stored_deflate_encoder_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("png_stored_deflate_encoder_top_test: FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/pngenc_pkg.sv
rtl/pngenc_if.sv
rtl/pngenc_queue.sv
rtl/pngenc_div.sv
rtl/pngenc_seq.sv
rtl/png_stored_deflate_encoder_top.sv
verif/png_stored_deflate_encoder_top_test.sv
